[rtl/wlfo_pkg.sv]
// Package for the wavetable LFO: field widths, request and register codes,
// controller state type and the command/status structs between the modules.
// No dependencies.
`timescale 1ns / 1ps

package wlfo_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 24;
    localparam int LEN_W      = 7;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 8;
    localparam int REQ_W      = 2;
    localparam int IN_TDATA_W = 48;
    localparam int CFG_IDX_W  = 1;

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 24'd1000;
    localparam logic [LEN_W-1:0]    RESET_LENGTH = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_RDA,
        S_RDB,
        S_MIX
    } t_lfo_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_init;
        logic div_step;
        logic rd_a;
        logic rd_b;
        logic mix;
    } t_dp_cmd;

    typedef struct packed {
        logic past_end;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/wavetable_lfo_interpolated.sv]
// Ticks run multiply, divider init, a QW-bit divide (QW = 7 + FRAC_BITS,
// 23 by default; skipped when past the last entry), two table reads and mix.
// The divider yields one quotient bit per cycle; input is ready only in idle,
// so a new request waits until the last tick is done. Config is always ready.
// Reset: period 1000, length 64, phase and last time zero; table undefined.
// Top level of the wavetable LFO; instantiates wlfo_ctrl and wlfo_dp.
`timescale 1ns / 1ps

module wavetable_lfo_interpolated #(
    parameter int TABLE_DEPTH = wlfo_pkg::DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = wlfo_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] time_ms, [37:32] table_addr, [45:38] table_data, [47:46] zero
    input  logic [wlfo_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [1:0] req_type
    input  logic [wlfo_pkg::REQ_W-1:0]          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] sample
    output logic [wlfo_pkg::DATA_W-1:0]         o_m_tdata,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wlfo_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [wlfo_pkg::PERIOD_W-1:0]       i_cfg_data
);

    wlfo_pkg::t_dp_cmd    w_cmd;
    wlfo_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    wlfo_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req      (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wlfo_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_req       (i_s_tuser),
        .i_time      (i_s_tdata[31:0]),
        .i_waddr     (i_s_tdata[37:32]),
        .i_wdata     (i_s_tdata[45:38]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

[rtl/wlfo_ctrl.sv]
// Controller FSM for the wavetable LFO: input handshake and sequencing of
// multiply, divide, table reads and mix. Depends on wlfo_pkg.
`timescale 1ns / 1ps

module wlfo_ctrl #(
    parameter int FRAC_BITS = wlfo_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [wlfo_pkg::REQ_W-1:0]   i_req,
    output logic                         o_s_tready,
    input  wlfo_pkg::t_dp_status         i_status,
    output wlfo_pkg::t_dp_cmd            o_cmd
);

    localparam int QW    = wlfo_pkg::LEN_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    wlfo_pkg::t_lfo_state r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 w_accept;

    assign o_s_tready = (r_state == wlfo_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlfo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == wlfo_pkg::S_DINIT) begin
            r_cnt <= '0;
        end else if (r_state == wlfo_pkg::S_DIV) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wlfo_pkg::S_IDLE: begin
                if (w_accept && (i_req == wlfo_pkg::REQ_TICK)) begin
                    n_state = wlfo_pkg::S_MUL;
                end
            end
            wlfo_pkg::S_MUL: begin
                n_state = i_status.past_end ? wlfo_pkg::S_RDA : wlfo_pkg::S_DINIT;
            end
            wlfo_pkg::S_DINIT: n_state = wlfo_pkg::S_DIV;
            wlfo_pkg::S_DIV: begin
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_state = wlfo_pkg::S_RDA;
                end
            end
            wlfo_pkg::S_RDA: n_state = wlfo_pkg::S_RDB;
            wlfo_pkg::S_RDB: n_state = wlfo_pkg::S_MIX;
            wlfo_pkg::S_MIX: begin
                if (i_status.out_free) begin
                    n_state = wlfo_pkg::S_IDLE;
                end
            end
            default: n_state = wlfo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        unique case (r_state)
            wlfo_pkg::S_IDLE:  ;
            wlfo_pkg::S_MUL:   o_cmd.mul      = 1'b1;
            wlfo_pkg::S_DINIT: o_cmd.div_init = 1'b1;
            wlfo_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            wlfo_pkg::S_RDA:   o_cmd.rd_a     = 1'b1;
            wlfo_pkg::S_RDB:   o_cmd.rd_b     = 1'b1;
            wlfo_pkg::S_MIX:   o_cmd.mix      = i_status.out_free;
            default: ;
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wlfo_pkg::S_DIV) |-> (r_cnt < CNT_W'(QW)))
        else $error("divide counter out of range");

endmodule

[rtl/wlfo_dp.sv]
// Datapath for the wavetable LFO: config registers, phase accumulator,
// multiplier, restoring divider, wave table memory, interpolator, output reg.
// Depends on wlfo_pkg.
`timescale 1ns / 1ps

module wlfo_dp #(
    parameter int TABLE_DEPTH = wlfo_pkg::DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = wlfo_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wlfo_pkg::t_dp_cmd                i_cmd,
    output wlfo_pkg::t_dp_status             o_status,
    input  logic [wlfo_pkg::REQ_W-1:0]       i_req,
    input  logic [wlfo_pkg::TIME_W-1:0]      i_time,
    input  logic [wlfo_pkg::ADDR_W-1:0]      i_waddr,
    input  logic [wlfo_pkg::DATA_W-1:0]      i_wdata,
    input  logic                             i_cfg_valid,
    input  logic [wlfo_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [wlfo_pkg::PERIOD_W-1:0]    i_cfg_data,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [wlfo_pkg::DATA_W-1:0]      o_m_tdata,
    output logic                             o_m_tlast
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int LW       = wlfo_pkg::LEN_W;
    localparam int TW       = wlfo_pkg::TIME_W;
    localparam int PW       = wlfo_pkg::PERIOD_W;
    localparam int DW       = wlfo_pkg::DATA_W;
    localparam int QW       = LW + FRAC_BITS;
    localparam int PROD_W   = TW + LW;
    localparam int MIX_W    = DW + FRAC_BITS + 1;
    localparam int ADDR_W_X = wlfo_pkg::ADDR_W + AW;

    logic [PW-1:0]     r_period;
    logic [LW-1:0]     r_length;
    logic [TW-1:0]     r_last;
    logic [TW-1:0]     r_phase;
    logic [TW-1:0]     r_cur;
    logic              r_past;
    logic              r_wrap;
    logic [PROD_W-1:0] r_prod;
    logic [PW-1:0]     r_rem;
    logic [QW-1:0]     r_nsh;
    logic [QW-1:0]     r_q;
    logic [DW-1:0]     r_a;
    logic [DW-1:0]     r_rd;
    logic [DW-1:0]     r_mem [TABLE_DEPTH];
    logic              r_out_valid;
    logic [DW-1:0]     r_out_data;
    logic              r_out_last;

    logic [LW-1:0]          w_len_nz;
    logic [LW-1:0]          w_lm1;
    logic [TW-1:0]          w_phase_new;
    logic                   w_wrap;
    logic [PW:0]            w_trial;
    logic [PW:0]            w_diff;
    logic                   w_ge;
    logic [LW-1:0]          w_idx;
    logic [LW-1:0]          w_idx_b;
    logic [LW-1:0]          w_ra_sel;
    logic [LW+AW-1:0]       w_raddr_x;
    logic [ADDR_W_X-1:0]    w_waddr_x;
    logic                   w_wr_en;
    logic [FRAC_BITS-1:0]   w_frac;
    logic [FRAC_BITS:0]     w_inv;
    logic [MIX_W-1:0]       w_mix;
    logic [DW-1:0]          w_sample;

    // used length: zero counts as one, saturate at table depth
    always_comb begin
        w_len_nz = (r_length == '0) ? LW'(1) : r_length;
        if (32'(w_len_nz) > TABLE_DEPTH) begin
            w_lm1 = LW'(TABLE_DEPTH - 1);
        end else begin
            w_lm1 = w_len_nz - 1'b1;
        end
    end

    assign w_phase_new = r_phase + (i_time - r_last);
    assign w_wrap      = (w_phase_new >= TW'(r_period));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= wlfo_pkg::RESET_PERIOD;
            r_length <= wlfo_pkg::RESET_LENGTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                wlfo_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                wlfo_pkg::CFG_LENGTH: r_length <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_phase <= '0;
        end else if (i_cmd.accept) begin
            unique case (i_req)
                wlfo_pkg::REQ_TICK: begin
                    r_last  <= i_time;
                    r_phase <= w_wrap ? '0 : w_phase_new;
                end
                wlfo_pkg::REQ_RESTART: r_phase <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_req == wlfo_pkg::REQ_TICK)) begin
            r_cur  <= w_phase_new;
            r_wrap <= w_wrap;
            r_past <= w_wrap || (w_lm1 == '0);
        end
    end

    // quotient fits QW bits, so the top of the numerator starts the remainder
    assign w_trial = {r_rem, r_nsh[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_period});
    assign w_diff  = w_trial - {1'b0, r_period};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_cur) * PROD_W'(w_lm1);
        end
        if (i_cmd.div_init) begin
            r_rem <= r_prod[LW+PW-1:LW];
            r_nsh <= {r_prod[LW-1:0], {FRAC_BITS{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
            r_nsh <= {r_nsh[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign w_idx     = r_q[QW-1:FRAC_BITS];
    assign w_idx_b   = w_idx + 1'b1;
    assign w_ra_sel  = i_cmd.rd_b ? w_idx_b : (r_past ? w_lm1 : w_idx);
    assign w_raddr_x = {{AW{1'b0}}, w_ra_sel};
    assign w_waddr_x = {{AW{1'b0}}, i_waddr};
    assign w_wr_en   = i_cmd.accept && (i_req == wlfo_pkg::REQ_WRITE)
                       && (32'(i_waddr) < TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_waddr_x[AW-1:0]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_rd <= r_mem[w_raddr_x[AW-1:0]];
        end
        if (i_cmd.rd_b) begin
            r_a <= r_rd;
        end
    end

    assign w_frac   = r_q[FRAC_BITS-1:0];
    assign w_inv    = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, w_frac};
    assign w_mix    = MIX_W'(r_a) * MIX_W'(w_inv) + MIX_W'(r_rd) * MIX_W'(w_frac);
    assign w_sample = r_past ? r_a : w_mix[FRAC_BITS+DW-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.mix) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_out_data <= w_sample;
            r_out_last <= r_wrap;
        end
    end

    assign o_status.past_end = r_past;
    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;
    assign o_m_tlast         = r_out_last;

    a_rem_lt_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_period))
        else $error("divider remainder not below period");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_a && !r_past) |-> (w_idx < w_lm1))
        else $error("table index past last entry");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && (i_req == wlfo_pkg::REQ_TICK))
        |=> ((r_phase < TW'(r_period)) || (r_phase == '0)))
        else $error("phase not restarted at period");

endmodule
